[rtl/bkspf_pkg.sv]
// Package for the base58 key span finder: payload structs, symbol class codes,
// register indexes and reset values. Depends on nothing; used by every module.
package bkspf_pkg;

  localparam int unsigned MaxBufferBytes = 4096;
  localparam int unsigned SymbolCount    = 58;
  localparam int unsigned LenW           = 6;
  localparam int unsigned StartW         = 12;
  localparam int unsigned CfgAddrW       = 4;
  localparam int unsigned CfgDataW       = 32;

  localparam logic [LenW-1:0] RunSat          = 6'd63;
  localparam logic [LenW-1:0] ResetMinSpan    = 6'd32;
  localparam logic [LenW-1:0] ResetMaxSpan    = 6'd44;
  localparam logic [LenW-1:0] ResetMinDistinct = 6'd12;

  localparam logic [2:0] ClassNone  = 3'b000;
  localparam logic [2:0] ClassDigit = 3'b001;
  localparam logic [2:0] ClassUpper = 3'b010;
  localparam logic [2:0] ClassLower = 3'b100;
  localparam logic [2:0] ClassAll   = 3'b111;

  typedef enum logic [1:0] {
    RegMinSpan     = 2'd0,
    RegMaxSpan     = 2'd1,
    RegMinDistinct = 2'd2,
    RegUnused      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [StartW-1:0] span_start;
    logic [LenW-1:0]   span_length;
    logic              high_confidence;
  } out_item_t;

  typedef struct packed {
    logic       is_symbol;
    logic [5:0] index;
    logic [2:0] char_class;
  } sym_info_t;

endpackage

[rtl/bkspf_classify.sv]
// Base58 byte classifier: maps a byte to its alphabet index and character class.
// Depends on bkspf_pkg for the sym_info_t struct and the class codes.
module bkspf_classify import bkspf_pkg::*; (
  input  logic [7:0] data_byte_i,
  output sym_info_t  info_o
);

  logic [7:0] offset;

  always_comb begin
    info_o = '{is_symbol: 1'b1, index: 6'd0, char_class: ClassNone};
    offset = 8'd0;
    if (data_byte_i >= 8'h31 && data_byte_i <= 8'h39) begin
      offset = data_byte_i - 8'd49;
      info_o.char_class = ClassDigit;
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h48) begin
      offset = data_byte_i - 8'd56;
      info_o.char_class = ClassUpper;
    end else if (data_byte_i >= 8'h4a && data_byte_i <= 8'h4e) begin
      offset = data_byte_i - 8'd57;
      info_o.char_class = ClassUpper;
    end else if (data_byte_i >= 8'h50 && data_byte_i <= 8'h5a) begin
      offset = data_byte_i - 8'd58;
      info_o.char_class = ClassUpper;
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h6b) begin
      offset = data_byte_i - 8'd64;
      info_o.char_class = ClassLower;
    end else if (data_byte_i >= 8'h6d && data_byte_i <= 8'h7a) begin
      offset = data_byte_i - 8'd65;
      info_o.char_class = ClassLower;
    end else begin
      info_o.is_symbol = 1'b0;
    end
    info_o.index = offset[5:0];
  end

endmodule

[rtl/base58_key_span_finder_unit.sv]
// Top level of the base58 key span finder: APB register file, input register,
// run tracking state and result register. Depends on bkspf_pkg and bkspf_classify.
// The byte ending a run is held in the input register, then its result in the result register.
// Throughput: one byte per cycle, set by the run state update, while no result waits unaccepted.
// While a result waits unaccepted, the input register takes at most one byte and then stalls.
// Reset: asynchronous, active low; registers return to 32, 44 and 12 and all run state
// and the byte position clear to zero.
module base58_key_span_finder_unit import bkspf_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = MaxBufferBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned PosW = $clog2(MAX_BUFFER_BYTES);
  localparam logic [PosW-1:0] PosSat = PosW'(MAX_BUFFER_BYTES - 1);

  logic [LenW-1:0] min_span_q, max_span_q, min_distinct_q;
  cfg_reg_e        cfg_sel;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_span_q     <= ResetMinSpan;
      max_span_q     <= ResetMaxSpan;
      min_distinct_q <= ResetMinDistinct;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        RegMinSpan:     min_span_q     <= pwdata[LenW-1:0];
        RegMaxSpan:     max_span_q     <= pwdata[LenW-1:0];
        RegMinDistinct: min_distinct_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegMinSpan:     prdata = {{(CfgDataW-LenW){1'b0}}, min_span_q};
      RegMaxSpan:     prdata = {{(CfgDataW-LenW){1'b0}}, max_span_q};
      RegMinDistinct: prdata = {{(CfgDataW-LenW){1'b0}}, min_distinct_q};
      default:        prdata = '0;
    endcase
  end

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     advance;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  sym_info_t sym;

  bkspf_classify u_classify (
    .data_byte_i (in_item_q.data_byte),
    .info_o      (sym)
  );

  logic [PosW-1:0]        pos_q, pos_d;
  logic [PosW-1:0]        start_q, start_d;
  logic [LenW-1:0]        run_len_q, run_len_d;
  logic [2:0]             class_q, class_d;
  logic [SymbolCount-1:0] mask_q, mask_d;
  logic [LenW-1:0]        distinct_q, distinct_d;
  logic [LenW-1:0]        lo_bound;
  logic                   run_end, emit, high;
  logic [PosW+StartW-1:0] start_ext;
  out_item_t              result;

  always_comb begin
    start_d    = start_q;
    run_len_d  = run_len_q;
    class_d    = class_q;
    mask_d     = mask_q;
    distinct_d = distinct_q;
    if (sym.is_symbol) begin
      if (run_len_q == '0) begin
        start_d = pos_q;
      end
      if (run_len_q != RunSat) begin
        run_len_d = run_len_q + 1'b1;
      end
      class_d = class_q | sym.char_class;
      if (!mask_q[sym.index]) begin
        mask_d[sym.index] = 1'b1;
        distinct_d        = distinct_q + 1'b1;
      end
    end

    lo_bound  = (min_span_q == '0) ? 6'd1 : min_span_q;
    run_end   = (!sym.is_symbol || in_item_q.last_byte) && (run_len_d != '0);
    emit      = run_end && (run_len_d != RunSat) && (run_len_d >= lo_bound) &&
                (run_len_d <= max_span_q);
    high      = (class_d == ClassAll) && (distinct_d >= min_distinct_q);
    start_ext = {{StartW{1'b0}}, start_d};
    result    = '{span_start: start_ext[StartW-1:0], span_length: run_len_d,
                  high_confidence: high};

    if (run_end || in_item_q.last_byte) begin
      start_d    = '0;
      run_len_d  = '0;
      class_d    = ClassNone;
      mask_d     = '0;
      distinct_d = '0;
    end

    if (in_item_q.last_byte) begin
      pos_d = '0;
    end else if (pos_q != PosSat) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      start_q    <= '0;
      run_len_q  <= '0;
      class_q    <= ClassNone;
      mask_q     <= '0;
      distinct_q <= '0;
    end else if (advance) begin
      pos_q      <= pos_d;
      start_q    <= start_d;
      run_len_q  <= run_len_d;
      class_q    <= class_d;
      mask_q     <= mask_d;
      distinct_q <= distinct_d;
    end
  end

  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_o <= result;
    end
  end

  // An idle run holds no symbol history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_len_q == '0) |-> (mask_q == '0 && distinct_q == '0 && class_q == ClassNone))
    else $error("run state not cleared while no run is open");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q == LenW'($countones(mask_q)))
    else $error("distinct symbol count disagrees with the seen mask");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= run_len_q)
    else $error("more distinct symbols than bytes in the run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (out_valid_o && out_data_o.span_length != '0 &&
                           out_data_o.span_length != RunSat))
    else $error("reported span has an impossible length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.last_byte) |=> (pos_q == '0 && run_len_q == '0))
    else $error("buffer end did not restart the scan");

endmodule

[sim/base58_key_span_finder_unit_test.sv]
// Testbench for base58_key_span_finder_unit: a directed sequence and random byte buffers with key-like runs,
// checked against a scoreboard that predicts every reported span from the accepted bytes.
// Depends on bkspf_pkg and the block's RTL only.
module base58_key_span_finder_unit_test;
  import bkspf_pkg::*;

  localparam int unsigned StallMax = 15;

  class span_scoreboard;
    logic [LenW-1:0]        cfg_regs [3];
    logic [StartW-1:0]      position;
    logic [StartW-1:0]      run_start;
    logic [LenW-1:0]        run_len;
    logic [LenW-1:0]        distinct;
    logic [2:0]             classes;
    logic [SymbolCount-1:0] seen;
    out_item_t              pending_spans [$];
    int                     errors;

    function new();
      cfg_regs[RegMinSpan] = ResetMinSpan;
      cfg_regs[RegMaxSpan] = ResetMaxSpan;
      cfg_regs[RegMinDistinct] = ResetMinDistinct;
      position = '0;
      errors = 0;
      clear_run();
    endfunction

    static function sym_info_t classify(logic [7:0] c);
      sym_info_t s;
      s = '{is_symbol: 1'b1, index: 6'd0, char_class: ClassNone};
      if (c >= "1" && c <= "9") begin
        s.index = 6'(c - "1");
        s.char_class = ClassDigit;
      end else if (c >= "A" && c <= "H") begin
        s.index = 6'(c - "A" + 8'd9);
        s.char_class = ClassUpper;
      end else if (c >= "J" && c <= "N") begin
        s.index = 6'(c - "J" + 8'd17);
        s.char_class = ClassUpper;
      end else if (c >= "P" && c <= "Z") begin
        s.index = 6'(c - "P" + 8'd22);
        s.char_class = ClassUpper;
      end else if (c >= "a" && c <= "k") begin
        s.index = 6'(c - "a" + 8'd33);
        s.char_class = ClassLower;
      end else if (c >= "m" && c <= "z") begin
        s.index = 6'(c - "m" + 8'd44);
        s.char_class = ClassLower;
      end else begin
        s.is_symbol = 1'b0;
      end
      return s;
    endfunction

    function void clear_run();
      run_len = '0;
      run_start = '0;
      classes = ClassNone;
      seen = '0;
      distinct = '0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [LenW-1:0] value);
      if (r != RegUnused) begin
        cfg_regs[r] = value;
      end
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function void note_byte(in_item_t item);
      sym_info_t       s;
      logic [LenW-1:0] lo;
      out_item_t       span;
      s = classify(item.data_byte);
      if (s.is_symbol) begin
        if (run_len == 0) begin
          clear_run();
          run_start = position;
        end
        if (run_len != RunSat) begin
          run_len++;
        end
        classes |= s.char_class;
        if (!seen[s.index]) begin
          seen[s.index] = 1'b1;
          distinct++;
        end
      end
      if ((!s.is_symbol || item.last_byte) && run_len != 0) begin
        // A minimum of zero behaves like one.
        lo = (cfg_regs[RegMinSpan] == 0) ? 6'd1 : cfg_regs[RegMinSpan];
        if (run_len != RunSat && run_len >= lo && run_len <= cfg_regs[RegMaxSpan]) begin
          span.span_start = run_start;
          span.span_length = run_len;
          span.high_confidence = (classes == ClassAll) &&
                                 (distinct >= cfg_regs[RegMinDistinct]);
          pending_spans = {pending_spans, span};
        end
        clear_run();
      end
      if (item.last_byte) begin
        position = '0;
        clear_run();
      end else if (position != StartW'(MaxBufferBytes - 1)) begin
        position++;
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_spans.size() == 0) begin
        report("span with none pending, start", got.span_start, -1);
        return;
      end
      want = pending_spans.pop_front();
      if (got.span_start !== want.span_start) begin
        report("span_start", got.span_start, want.span_start);
      end
      if (got.span_length !== want.span_length) begin
        report("span_length", got.span_length, want.span_length);
      end
      if (got.high_confidence !== want.high_confidence) begin
        report("high_confidence", got.high_confidence, want.high_confidence);
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  span_scoreboard sb = new();
  string          base58_chars =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  logic [7:0]     scan_bytes [$];
  bit             idle_on;
  int             items_sent;

  base58_key_span_finder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_data_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_byte(in_data_i);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, StallMax)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  function automatic void append_byte(input logic [7:0] value);
    scan_bytes = {scan_bytes, value};
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic is_last);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, StallMax)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = '{data_byte: value, last_byte: is_last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string text, input bit mark_last);
    for (int i = 0; i < text.len(); i++) begin
      push_byte(text[i], mark_last && (i == text.len() - 1));
    end
  endtask

  task automatic apb_write(input cfg_reg_e r, input logic [CfgDataW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_read(input cfg_reg_e r, output logic [CfgDataW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {r, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_register(input cfg_reg_e r, input logic [LenW-1:0] value);
    apb_write(r, {26'($urandom), value});
    sb.set_reg(r, value);
  endtask

  task automatic check_registers();
    logic [CfgDataW-1:0] value;
    cfg_reg_e            r;
    r = RegMinSpan;
    repeat (3) begin
      apb_read(r, value);
      if (value[LenW-1:0] !== sb.cfg_regs[r]) begin
        sb.report($sformatf("register %s", r.name()), value[LenW-1:0], sb.cfg_regs[r]);
      end
      r = r.next();
    end
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending_spans.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_other();
    logic [7:0] c;
    sym_info_t  s;
    do begin
      c = 8'($urandom_range(0, 255));
      s = span_scoreboard::classify(c);
    end while (s.is_symbol);
    return c;
  endfunction

  task automatic add_key_run(input int len);
    int base;
    int variety;
    base = $urandom_range(0, SymbolCount - 1);
    variety = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : SymbolCount;
    repeat (len) begin
      append_byte(base58_chars[(base + $urandom_range(0, variety - 1)) % SymbolCount]);
    end
  endtask

  task automatic send_scan_bytes();
    foreach (scan_bytes[i]) begin
      push_byte(scan_bytes[i], i == scan_bytes.size() - 1);
    end
  endtask

  task automatic send_random_buffer(input bit allow_idle);
    int segments;
    int len;
    int lo;
    int hi;
    scan_bytes.delete();
    idle_on = allow_idle && ($urandom_range(0, 3) != 0);
    segments = $urandom_range(1, 4);
    for (int seg = 0; seg < segments; seg++) begin
      if ($urandom_range(0, 4) != 0) begin
        lo = (sb.cfg_regs[RegMinSpan] > 2) ? sb.cfg_regs[RegMinSpan] - 2 : 1;
        hi = (sb.cfg_regs[RegMaxSpan] + 2 > 66) ? 66 : sb.cfg_regs[RegMaxSpan] + 2;
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(58, 70);
        end else if (lo > hi) begin
          len = $urandom_range(1, 62);
        end else begin
          len = $urandom_range(lo, hi);
        end
        add_key_run(len);
        repeat ((seg == segments - 1) ? $urandom_range(0, 2) : $urandom_range(1, 3)) begin
          append_byte(pick_other());
        end
      end else begin
        repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
      end
    end
    send_scan_bytes();
  endtask

  task automatic run_phase(input logic [LenW-1:0] min_len, input logic [LenW-1:0] max_len,
                           input logic [LenW-1:0] min_distinct, input int target,
                           input bit allow_idle);
    int stop_at;
    set_register(RegMinSpan, min_len);
    set_register(RegMaxSpan, max_len);
    set_register(RegMinDistinct, min_distinct);
    check_registers();
    stop_at = items_sent + target;
    while (items_sent < stop_at) send_random_buffer(allow_idle);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b0;
    items_sent = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_registers();
    apb_write(RegUnused, $urandom);

    set_register(RegMinSpan, 6'd1);
    set_register(RegMaxSpan, 6'd62);
    set_register(RegMinDistinct, 6'd3);
    check_registers();
    send_text("1Aa", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_text("0IOl", 1'b0);
    send_text("9ZzHJNPkm", 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte("1", 1'b1);
    send_text("111 ", 1'b0);
    wait_idle();

    run_phase(ResetMinSpan, ResetMaxSpan, ResetMinDistinct, 350, 1'b1);
    run_phase(6'd1, 6'd62, 6'd0, 250, 1'b1);
    run_phase(6'd62, 6'd62, 6'd58, 250, 1'b1);
    run_phase(6'd0, 6'd63, 6'd63, 250, 1'b1);
    run_phase(6'd20, 6'd10, 6'd5, 150, 1'b1);
    run_phase(6'd8, 6'd24, 6'd6, 350, 1'b0);

    repeat (10) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("FAIL");
    $finish;
  end

endmodule
